/* hdl/sib_pkg.sv */
// Package for the subpixel interval bounds block.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package sib_pkg;

	localparam int CH_W = 8;
	localparam int PIX_W = 3 * CH_W;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_DATA_W = 6 * CH_W;

	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 13'd1024;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	// Which of the four neighbours are inside the frame.
	typedef struct packed {
		logic has_left;
		logic has_right;
		logic has_up;
		logic has_down;
	} nbr_flags_t;

endpackage

/* hdl/subpixel_interval_bounds.sv */
// Top level of the subpixel interval bounds block.
// Depends on sib_pkg, sib_ram, sib_cell and sib_bound.
//
// Usage: pixels enter on the s_ channel in raster order, one request per
// pixel, s_tuser low; s_tdata holds red, green and blue from bit 0 up (gray
// images use red). Results leave on the m_ channel and lag one row: the
// result for pixel (x,y-1) is produced by the request carrying (x,y). After
// the last row the source sends image_width drain requests (s_tuser high,
// data ignored) to flush that row; the final one carries m_tlast. A drain
// request sent while pixels are still expected is dropped.
// Throughput is one request per clock while m_tready keeps the output moving.
// A taken request loads the row store read and the compute stage; when that
// stage advances, its bounds are loaded into the output register.
// Two row stores of MAX_WIDTH entries (rows y-1 and y-2) feed a window of
// three column cells; they need no clearing pass after reset.
// Reset clears the counters, the registers to width 1024 and height 1024,
// and empties the pipeline. When m_tready is low the result waits in the
// output register, one more request may be held in the compute stage, and
// s_tready falls once both are full.
// Write registers over cfg_wr_en/cfg_index/cfg_data only while idle; not enforced.
module subpixel_interval_bounds #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_wr_en,
	input  logic [sib_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sib_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sib_pkg::PIX_W-1:0]          s_tdata,  // chan_red, chan_green, chan_blue
	input  logic                               s_tuser,  // kind
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sib_pkg::OUT_DATA_W-1:0]     m_tdata,  // min_red, min_green, min_blue,
	                                                     // max_red, max_green, max_blue
	output logic                               m_tlast   // frame_end
);

	import sib_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);

	// Configuration and frame position.
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [CW-1:0]           col_q;
	logic [HEIGHT_REG_W-1:0] row_q;

	logic [WW-1:0]           w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic                    in_last;
	logic                    in_drain;
	logic                    accept;
	logic                    take;
	logic [CW-1:0]           rd_addr;

	// Compute stage.
	logic                    s1_v_q;
	logic                    s1_res_s1;
	logic                    s1_drain_s1;
	logic                    s1_last_s1;
	logic                    s1_fend_s1;
	logic                    s1_fwd_s1;
	logic                    s1_hl_s1;
	logic                    s1_hu_s1;
	logic [CW-1:0]           s1_x_s1;
	logic [PIX_W-1:0]        s1_px_s1;
	logic                    s1_adv;
	logic                    wr_en;

	// Window and row store data.
	logic [PIX_W-1:0]        rd_mid;
	logic [PIX_W-1:0]        rd_up;
	logic [PIX_W-1:0]        ctr_d;
	logic [PIX_W-1:0]        up_d;
	logic [PIX_W-1:0]        ctr_pix;
	logic [PIX_W-1:0]        up_pix;
	logic [PIX_W-1:0]        left_pix;
	logic                    shift;
	nbr_flags_t              flags;
	logic [CH_W-1:0]         lo [3];
	logic [CH_W-1:0]         hi [3];

	// Output register.
	logic                    out_v_q;
	logic [OUT_DATA_W-1:0]   out_data_q;
	logic                    out_last_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, width limited to the stores.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q == '0) ? HEIGHT_REG_W'(1) : height_q;
	end

	// Classify the incoming request against the frame position.
	assign in_last = (WW'(col_q) + WW'(1)) >= w_eff;
	assign in_drain = row_q >= h_eff;
	assign s_tready = !s1_v_q || s1_adv;
	assign accept = s_tvalid && s_tready;
	assign take = accept && (in_drain || !s_tuser);
	// Look one column ahead; the last column fetches the next row's first.
	assign rd_addr = in_last ? '0 : col_q + CW'(1);

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (in_last) begin
				col_q <= '0;
				row_q <= in_drain ? '0 : row_q + HEIGHT_REG_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Compute stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (take) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	// Compute stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			s1_res_s1 <= in_drain || (row_q != '0);
			s1_drain_s1 <= in_drain;
			s1_last_s1 <= in_last;
			s1_fend_s1 <= in_drain && in_last;
			s1_fwd_s1 <= !in_drain && in_last && (col_q == '0);
			s1_hl_s1 <= col_q != '0;
			s1_hu_s1 <= row_q > HEIGHT_REG_W'(1);
			s1_x_s1 <= col_q;
			s1_px_s1 <= s_tdata;
		end
	end

	assign s1_adv = s1_v_q && (!s1_res_s1 || !out_v_q || m_tready);
	assign shift = s1_adv;
	assign wr_en = s1_adv && !s1_drain_s1;

	// Row stores: row y-1 and row y-2.
	sib_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prior_row (
		.clk(clk),
		.we(wr_en),
		.waddr(s1_x_s1),
		.wdata(s1_px_s1),
		.re(take),
		.raddr(rd_addr),
		.rdata(rd_mid)
	);

	sib_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_row (
		.clk(clk),
		.we(wr_en),
		.waddr(s1_x_s1),
		.wdata(ctr_pix),
		.re(take),
		.raddr(rd_addr),
		.rdata(rd_up)
	);

	// A one-column frame reads back the column this request writes.
	assign ctr_d = s1_fwd_s1 ? s1_px_s1 : rd_mid;
	assign up_d = s1_fwd_s1 ? ctr_pix : rd_up;

	// Window cells: right read data -> centre -> left.
	sib_cell u_ctr_cell (.clk(clk), .load(shift), .d(ctr_d), .q(ctr_pix));
	sib_cell u_up_cell (.clk(clk), .load(shift), .d(up_d), .q(up_pix));
	sib_cell u_left_cell (.clk(clk), .load(shift), .d(ctr_pix), .q(left_pix));

	assign flags = '{
		has_left: s1_hl_s1,
		has_right: !s1_last_s1,
		has_up: s1_hu_s1,
		has_down: !s1_drain_s1
	};

	// One bounds lane per channel.
	for (genvar c = 0; c < 3; c++) begin : g_lane
		sib_bound u_bound (
			.ctr(ctr_pix[c*CH_W +: CH_W]),
			.left(left_pix[c*CH_W +: CH_W]),
			.right(rd_mid[c*CH_W +: CH_W]),
			.up(up_pix[c*CH_W +: CH_W]),
			.down(s1_px_s1[c*CH_W +: CH_W]),
			.flags(flags),
			.lo(lo[c]),
			.hi(hi[c])
		);
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv && s1_res_s1) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv && s1_res_s1) begin
			out_data_q <= {hi[2], hi[1], hi[0], lo[2], lo[1], lo[0]};
			out_last_q <= s1_fend_s1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

`ifndef SYNTH
	// A taken request always occupies the compute stage next cycle.
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> s1_v_q)
		else $error("taken request did not reach the compute stage");

	// Frame end is only flagged on the drain of the last column.
	a_fend_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_fend_s1) |-> (s1_drain_s1 && s1_last_s1 && s1_res_s1))
		else $error("frame end outside the last drain column");

	// Self forwarding only happens for a one-column row.
	a_fwd_col: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_fwd_s1) |-> (s1_last_s1 && (s1_x_s1 == '0) && !s1_drain_s1))
		else $error("row store forwarding outside a one-column row");

	// Each lower bound never exceeds its upper bound.
	a_lo_le_hi: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((out_data_q[7:0] <= out_data_q[31:24])
			&& (out_data_q[15:8] <= out_data_q[39:32])
			&& (out_data_q[23:16] <= out_data_q[47:40])))
		else $error("interval bound order violated");
`endif

endmodule

/* hdl/sib_ram.sv */
// Generic single write port, single read port RAM with registered read.
// Read data is updated only on a read enable; a read of the address being
// written returns the new data. No dependencies.
module sib_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, write data forwarded on an address match.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

endmodule

/* hdl/sib_cell.sv */
// One column cell of the neighbourhood window: holds one pixel of a row.
// Loads from its right-hand neighbour whenever the window shifts.
// Depends on sib_pkg.
module sib_cell (
	input  logic                      clk,
	input  logic                      load,
	input  logic [sib_pkg::PIX_W-1:0] d,
	output logic [sib_pkg::PIX_W-1:0] q
);

	import sib_pkg::*;

	logic [PIX_W-1:0] pix_q;

	// Shift in the neighbouring column when the window moves on.
	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= d;
		end
	end

	assign q = pix_q;

endmodule

/* hdl/sib_bound.sv */
// One channel lane: least and greatest of the centre and its four
// half-sums with the neighbours. Depends on sib_pkg.
module sib_bound (
	input  logic [sib_pkg::CH_W-1:0] ctr,
	input  logic [sib_pkg::CH_W-1:0] left,
	input  logic [sib_pkg::CH_W-1:0] right,
	input  logic [sib_pkg::CH_W-1:0] up,
	input  logic [sib_pkg::CH_W-1:0] down,
	input  sib_pkg::nbr_flags_t      flags,
	output logic [sib_pkg::CH_W-1:0] lo,
	output logic [sib_pkg::CH_W-1:0] hi
);

	import sib_pkg::*;

	logic [CH_W:0]   sum [4];
	logic [CH_W-1:0] half [4];
	logic [3:0]      has;

	assign has = {flags.has_down, flags.has_up, flags.has_right, flags.has_left};

	// Half-sums rounded down; an absent neighbour gives the centre itself.
	always_comb begin
		sum[0] = {1'b0, left} + {1'b0, ctr};
		sum[1] = {1'b0, right} + {1'b0, ctr};
		sum[2] = {1'b0, up} + {1'b0, ctr};
		sum[3] = {1'b0, down} + {1'b0, ctr};
		for (int k = 0; k < 4; k++) begin
			half[k] = has[k] ? sum[k][CH_W:1] : ctr;
		end
	end

	// Running minimum and maximum over the four half-sums.
	always_comb begin
		lo = ctr;
		hi = ctr;
		for (int k = 0; k < 4; k++) begin
			if (half[k] < lo) begin
				lo = half[k];
			end
			if (half[k] > hi) begin
				hi = half[k];
			end
		end
	end

endmodule
